>>> design/ael_pkg.sv
// ----------------------------------------------------------------------------
// Arithmetic expression lexer package
// Token kinds, run classes, character codes and the record that passes from
// the front part of the lexer to the token queue.
// ----------------------------------------------------------------------------
package ael_pkg;

   // Default width of the byte position counter.
   localparam int POS_BITS_DEFAULT = 16;

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Largest number value and largest token length.
   localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] LEN_MAX = 16'hFFFF;

   // Character codes.
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;

   // Token kinds as they appear on the result port.
   typedef enum logic [3:0] {
      KIND_NUMBER = 4'd0,
      KIND_WORD   = 4'd1,
      KIND_SPACE  = 4'd2,
      KIND_PLUS   = 4'd3,
      KIND_MINUS  = 4'd4,
      KIND_STAR   = 4'd5,
      KIND_SLASH  = 4'd6,
      KIND_LPAREN = 4'd7,
      KIND_RPAREN = 4'd8,
      KIND_BAD    = 4'd9,
      KIND_EOF    = 4'd10
   } kind_type;

   // Class of the open run, one-hot.
   typedef enum logic [3:0] {
      RUN_NONE   = 4'b0001,
      RUN_NUMBER = 4'b0010,
      RUN_WORD   = 4'b0100,
      RUN_SPACE  = 4'b1000
   } run_type;

   // One result token.
   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic [30:0] value;
      logic        ovf;
      logic [7:0]  chr;
   } token_type;

   // Up to three tokens caused by one input byte, in order; mask bit i marks
   // slot i as present.
   typedef struct packed {
      logic [2:0] mask;
      token_type  tok2;
      token_type  tok1;
      token_type  tok0;
   } entry_type;

endpackage

>>> design/ael_front.sv
// ----------------------------------------------------------------------------
// Arithmetic expression lexer front
// Classifies each text byte, keeps the open run and the decimal accumulator,
// and builds the group of tokens that the byte causes.
// ----------------------------------------------------------------------------
module ael_front #(
   parameter int POS_BITS = ael_pkg::POS_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         text_byte,
   input  logic               end_of_text,
   output logic               entry_push,
   output ael_pkg::entry_type entry
);

   // Multiply the accumulator by ten and add a digit, saturating.
   function automatic logic [31:0] add_digit(input logic [30:0] acc,
                                              input logic        sat,
                                              input logic [3:0]  digit);
      logic [34:0] wide;
      logic [31:0] res;
      wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {31'b0, digit};
      if (wide > {4'b0, ael_pkg::VAL_MAX}) begin
         res = {1'b1, ael_pkg::VAL_MAX};
      end else begin
         res = {sat, wide[30:0]};
      end
      return res;
   endfunction

   // Token kind of a run class.
   function automatic ael_pkg::kind_type run_kind(input ael_pkg::run_type cls);
      ael_pkg::kind_type k;
      case (cls)
         ael_pkg::RUN_NUMBER: k = ael_pkg::KIND_NUMBER;
         ael_pkg::RUN_WORD:   k = ael_pkg::KIND_WORD;
         default:             k = ael_pkg::KIND_SPACE;
      endcase
      return k;
   endfunction

   ael_pkg::run_type      run_class_ff, run_class_in;
   logic [15:0]           run_start_ff, run_start_in;
   logic [15:0]           run_length_ff, run_length_in;
   logic [30:0]           accum_ff, accum_in;
   logic                  sat_ff, sat_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;

   logic                  is_digit, is_letter, is_space, is_run_char, cont;
   logic [3:0]            digit;
   logic [15:0]           pos16, next_pos16, len_inc;
   logic [31:0]           cont_acc;
   ael_pkg::run_type      new_class;
   ael_pkg::kind_type     single_kind;
   logic [POS_BITS-1:0]   pos_plus;
   ael_pkg::token_type    tok_a, tok_b, tok_c;
   logic [2:0]            mask;

   // Byte classification.
   always_comb begin
      is_digit  = (text_byte >= ael_pkg::CHAR_ZERO) && (text_byte <= ael_pkg::CHAR_NINE);
      is_letter = ((text_byte >= ael_pkg::CHAR_LOW_A) && (text_byte <= ael_pkg::CHAR_LOW_Z)) ||
                  ((text_byte >= ael_pkg::CHAR_UP_A) && (text_byte <= ael_pkg::CHAR_UP_Z));
      is_space  = (text_byte == ael_pkg::CHAR_SPACE) ||
                  ((text_byte >= ael_pkg::CHAR_TAB) && (text_byte <= ael_pkg::CHAR_CR));
      is_run_char = is_digit || is_letter || is_space;
      digit = 4'(text_byte - ael_pkg::CHAR_ZERO);
      if (is_digit) begin
         new_class = ael_pkg::RUN_NUMBER;
      end else if (is_letter) begin
         new_class = ael_pkg::RUN_WORD;
      end else begin
         new_class = ael_pkg::RUN_SPACE;
      end
      case (text_byte)
         ael_pkg::CHAR_PLUS:   single_kind = ael_pkg::KIND_PLUS;
         ael_pkg::CHAR_MINUS:  single_kind = ael_pkg::KIND_MINUS;
         ael_pkg::CHAR_STAR:   single_kind = ael_pkg::KIND_STAR;
         ael_pkg::CHAR_SLASH:  single_kind = ael_pkg::KIND_SLASH;
         ael_pkg::CHAR_LPAREN: single_kind = ael_pkg::KIND_LPAREN;
         ael_pkg::CHAR_RPAREN: single_kind = ael_pkg::KIND_RPAREN;
         default:              single_kind = ael_pkg::KIND_BAD;
      endcase
   end

   // Whether the byte continues the open run.
   always_comb begin
      case (run_class_ff)
         ael_pkg::RUN_NUMBER: cont = is_digit;
         ael_pkg::RUN_WORD:   cont = is_digit || is_letter;
         ael_pkg::RUN_SPACE:  cont = is_space;
         default:             cont = 1'b0;
      endcase
   end

   // Extended run values and positions.
   always_comb begin
      pos_plus   = pos_ff + POS_BITS'(1);
      pos16      = 16'(pos_ff);
      next_pos16 = 16'(pos_plus);
      len_inc    = (run_length_ff == ael_pkg::LEN_MAX) ? run_length_ff
                                                       : run_length_ff + 16'd1;
      cont_acc   = add_digit(accum_ff, sat_ff, digit);
   end

   // Token group for this byte: closed run, then single or new run, then eof.
   always_comb begin
      tok_a = '0;
      tok_b = '0;
      tok_c = '0;
      mask  = 3'b000;
      tok_a.kind  = run_kind(run_class_ff);
      tok_a.start = run_start_ff;
      if (cont) begin
         tok_a.length = len_inc;
         if (run_class_ff == ael_pkg::RUN_NUMBER) begin
            tok_a.value = cont_acc[30:0];
            tok_a.ovf   = cont_acc[31];
         end
         mask[0] = end_of_text;
      end else begin
         tok_a.length = run_length_ff;
         if (run_class_ff == ael_pkg::RUN_NUMBER) begin
            tok_a.value = accum_ff;
            tok_a.ovf   = sat_ff;
         end
         mask[0] = (run_class_ff != ael_pkg::RUN_NONE);
      end
      tok_b.start  = pos16;
      tok_b.length = 16'd1;
      if (is_run_char) begin
         tok_b.kind = run_kind(new_class);
         if (is_digit) begin
            tok_b.value = {27'b0, digit};
         end
         mask[1] = !cont && end_of_text;
      end else begin
         tok_b.kind = single_kind;
         tok_b.chr  = text_byte;
         mask[1] = !cont;
      end
      tok_c.kind  = ael_pkg::KIND_EOF;
      tok_c.start = next_pos16;
      mask[2] = end_of_text;
   end

   assign entry_push = accept && (mask != 3'b000);
   assign entry      = '{mask: mask, tok2: tok_c, tok1: tok_b, tok0: tok_a};

   // Next run state.
   always_comb begin
      run_class_in  = run_class_ff;
      run_start_in  = run_start_ff;
      run_length_in = run_length_ff;
      accum_in      = accum_ff;
      sat_in        = sat_ff;
      pos_in        = pos_plus;
      if (end_of_text) begin
         run_class_in  = ael_pkg::RUN_NONE;
         run_start_in  = 16'd0;
         run_length_in = 16'd0;
         accum_in      = 31'd0;
         sat_in        = 1'b0;
         pos_in        = '0;
      end else if (cont) begin
         run_length_in = len_inc;
         if (run_class_ff == ael_pkg::RUN_NUMBER) begin
            accum_in = cont_acc[30:0];
            sat_in   = cont_acc[31];
         end
      end else if (is_run_char) begin
         run_class_in  = new_class;
         run_start_in  = pos16;
         run_length_in = 16'd1;
         accum_in      = is_digit ? {27'b0, digit} : 31'd0;
         sat_in        = 1'b0;
      end else begin
         run_class_in  = ael_pkg::RUN_NONE;
         run_length_in = 16'd0;
         accum_in      = 31'd0;
         sat_in        = 1'b0;
      end
   end

   // Run state registers, updated on each accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_class_ff  <= ael_pkg::RUN_NONE;
         run_start_ff  <= 16'd0;
         run_length_ff <= 16'd0;
         accum_ff      <= 31'd0;
         sat_ff        <= 1'b0;
         pos_ff        <= '0;
      end else if (accept) begin
         run_class_ff  <= run_class_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         accum_ff      <= accum_in;
         sat_ff        <= sat_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

>>> design/ael_back.sv
// ----------------------------------------------------------------------------
// Arithmetic expression lexer back
// Queues token groups from the front and hands them out one token per beat,
// marking the last token of each group.
// ----------------------------------------------------------------------------
module ael_back #(
   parameter int QUEUE_DEPTH = ael_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               entry_push,
   input  ael_pkg::entry_type entry,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output ael_pkg::token_type head_tok,
   output logic               head_last
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   ael_pkg::entry_type      q_ff [QUEUE_DEPTH];
   logic [2:0]              mask_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [2:0]              head_mask, rest_mask;
   ael_pkg::entry_type      head;
   logic                    do_pop, group_done;

   assign full  = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);

   // Head token: lowest slot still pending in the oldest group.
   always_comb begin
      head      = q_ff[rd_ff];
      head_mask = mask_ff[rd_ff];
      rest_mask = head_mask & (head_mask - 3'd1);
      if (head_mask[0]) begin
         head_tok = head.tok0;
      end else if (head_mask[1]) begin
         head_tok = head.tok1;
      end else begin
         head_tok = head.tok2;
      end
      head_last  = (rest_mask == 3'b000);
      do_pop     = pop && !empty;
      group_done = do_pop && head_last;
   end

   // Pointer and count updates.
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (entry_push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + PTR_BITS'(1);
      end
      if (group_done) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + PTR_BITS'(1);
      end
      if (entry_push && !group_done) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (!entry_push && group_done) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   // Control registers and pending masks.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            mask_ff[i] <= 3'b000;
         end
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
         if (do_pop) begin
            mask_ff[rd_ff] <= rest_mask;
         end
         if (entry_push) begin
            mask_ff[wr_ff] <= entry.mask;
         end
      end
   end

   // Token payload storage.
   always_ff @(posedge clock) begin
      if (entry_push) begin
         q_ff[wr_ff] <= entry;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("token queue count beyond depth");

   a_head_pending: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (head_mask != 3'b000))
      else $error("queue head holds no pending token");

   a_group_stays: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !head_last) |=> !empty)
      else $error("token group lost before its last token");

   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && head_tok.kind == ael_pkg::KIND_EOF) |-> head_last)
      else $error("end-of-text token not last of its group");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !entry_push)
      else $error("group written into a full queue");
`endif

endmodule

>>> design/arithmetic_expression_lexer_top.sv
// ----------------------------------------------------------------------------
// Arithmetic expression lexer
// Turns a byte stream into number, word, space, operator, bad and
// end-of-text tokens.
//
//   Channel   Ports                        Beat taken when
//   --------  ---------------------------  -------------------
//   request   req_*, push, full            push && !full
//   response  rsp_*, empty, pop            pop && !empty
//
// A byte is classified and the run state updated in the cycle it is taken.
// One byte per cycle is sustained while pop is held and each byte gives at
// most one token; a byte of two or three tokens holds the response side for
// as many beats, and the request side runs on until the group queue fills.
// The group queue holds QUEUE_DEPTH byte groups; full depends on it alone.
// Reset is synchronous and clears run state, position and queue.
// ----------------------------------------------------------------------------
module arithmetic_expression_lexer_top #(
   parameter int POS_BITS    = ael_pkg::POS_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = ael_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        empty,
   input  logic        pop,
   output logic [3:0]  rsp_token_kind,
   output logic [15:0] rsp_start_pos,
   output logic [15:0] rsp_token_length,
   output logic [30:0] rsp_number_value,
   output logic        rsp_value_overflow,
   output logic [7:0]  rsp_token_char,
   output logic        rsp_last_of_run
);

   logic               accept;
   logic               entry_push;
   ael_pkg::entry_type entry;
   ael_pkg::token_type head_tok;

   assign accept = push && !full;

   // Front: classification and run tracking.
   ael_front #(
      .POS_BITS (POS_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .entry_push  (entry_push),
      .entry       (entry)
   );

   // Back: group queue and token hand-out.
   ael_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .entry_push (entry_push),
      .entry      (entry),
      .full       (full),
      .empty      (empty),
      .pop        (pop),
      .head_tok   (head_tok),
      .head_last  (rsp_last_of_run)
   );

   assign rsp_token_kind     = head_tok.kind;
   assign rsp_start_pos      = head_tok.start;
   assign rsp_token_length   = head_tok.length;
   assign rsp_number_value   = head_tok.value;
   assign rsp_value_overflow = head_tok.ovf;
   assign rsp_token_char     = head_tok.chr;

endmodule

>>> dv/lexer_token_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lexer token checker
// Watches the byte and token channels of the lexer. For every byte beat taken
// it works out the tokens that the byte must give. Every token beat taken is
// compared field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lexer_token_checker
   import ael_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   input  logic        empty,
   input  logic        pop,
   input  logic [3:0]  rsp_token_kind,
   input  logic [15:0] rsp_start_pos,
   input  logic [15:0] rsp_token_length,
   input  logic [30:0] rsp_number_value,
   input  logic        rsp_value_overflow,
   input  logic [7:0]  rsp_token_char,
   input  logic        rsp_last_of_run,
   output int          mismatch_count,
   output int          tokens_outstanding
);

   typedef struct packed {
      token_type tok;
      logic      last;
   } predicted_token_type;

   // Tokens predicted but not yet seen on the token channel, oldest first.
   predicted_token_type predicted_tokens[$];

   // Own copy of the lexer's run state.
   run_type     run_cls;
   logic [15:0] run_first;
   logic [15:0] run_len;
   logic [30:0] accum;
   logic        accum_sat;
   logic [15:0] byte_pos;
   int          tokens_this_byte;

   function automatic logic is_digit(logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_letter(logic [7:0] c);
      return (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) || (c >= CHAR_UP_A && c <= CHAR_UP_Z);
   endfunction

   // Space, tab, line feed, vertical tab, form feed and carriage return.
   function automatic logic is_blank(logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic void clear_run_state();
      run_cls   = RUN_NONE;
      run_first = '0;
      run_len   = '0;
      accum     = '0;
      accum_sat = 1'b0;
      byte_pos  = '0;
   endfunction

   function automatic void queue_token(kind_type kind, logic [15:0] start,
                                       logic [15:0] len, logic [30:0] val,
                                       logic ovf, logic [7:0] chr);
      predicted_token_type t;
      t.tok.kind   = kind;
      t.tok.start  = start;
      t.tok.length = len;
      t.tok.value  = val;
      t.tok.ovf    = ovf;
      t.tok.chr    = chr;
      t.last       = 1'b0;
      predicted_tokens.push_back(t);
      tokens_this_byte++;
   endfunction

   // Emits the token of the open run, if there is one, and leaves no run open.
   function automatic void close_open_run();
      case (run_cls)
         RUN_NUMBER: queue_token(KIND_NUMBER, run_first, run_len, accum, accum_sat, 8'h00);
         RUN_WORD:   queue_token(KIND_WORD, run_first, run_len, '0, 1'b0, 8'h00);
         RUN_SPACE:  queue_token(KIND_SPACE, run_first, run_len, '0, 1'b0, 8'h00);
         default: ;
      endcase
      run_cls   = RUN_NONE;
      run_len   = '0;
      accum     = '0;
      accum_sat = 1'b0;
   endfunction

   // Decimal accumulation, saturating at the largest value.
   function automatic void accumulate_digit(logic [7:0] c);
      logic [34:0] sum;
      sum = {4'd0, accum} * 35'd10 + {27'd0, c - CHAR_ZERO};
      if (sum > {4'd0, VAL_MAX}) begin
         accum     = VAL_MAX;
         accum_sat = 1'b1;
      end else begin
         accum = sum[30:0];
      end
   endfunction

   function automatic void predict_tokens(logic [7:0] c, logic eot);
      logic     continues;
      kind_type op_kind;
      tokens_this_byte = 0;

      case (run_cls)
         RUN_NUMBER: continues = is_digit(c);
         RUN_WORD:   continues = is_digit(c) || is_letter(c);
         RUN_SPACE:  continues = is_blank(c);
         default:    continues = 1'b0;
      endcase

      if (continues) begin
         if (run_len != LEN_MAX) run_len++;
         if (run_cls == RUN_NUMBER) accumulate_digit(c);
      end else begin
         // A byte that breaks the run closes it first, then starts afresh.
         close_open_run();
         if (is_digit(c) || is_letter(c) || is_blank(c)) begin
            if (is_digit(c)) run_cls = RUN_NUMBER;
            else if (is_letter(c)) run_cls = RUN_WORD;
            else run_cls = RUN_SPACE;
            run_first = byte_pos;
            run_len   = 16'd1;
            accum     = '0;
            accum_sat = 1'b0;
            if (run_cls == RUN_NUMBER) accumulate_digit(c);
         end else begin
            case (c)
               CHAR_PLUS:   op_kind = KIND_PLUS;
               CHAR_MINUS:  op_kind = KIND_MINUS;
               CHAR_STAR:   op_kind = KIND_STAR;
               CHAR_SLASH:  op_kind = KIND_SLASH;
               CHAR_LPAREN: op_kind = KIND_LPAREN;
               CHAR_RPAREN: op_kind = KIND_RPAREN;
               default:     op_kind = KIND_BAD;
            endcase
            queue_token(op_kind, byte_pos, 16'd1, '0, 1'b0, c);
         end
      end

      // The position wraps at the width of the counter.
      byte_pos++;

      if (eot) begin
         close_open_run();
         queue_token(KIND_EOF, byte_pos, '0, '0, 1'b0, 8'h00);
         clear_run_state();
      end

      if (tokens_this_byte > 0) predicted_tokens[predicted_tokens.size() - 1].last = 1'b1;
   endfunction

   function automatic void compare_field(string field, longint unsigned want,
                                         longint unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   function automatic void compare_token();
      predicted_token_type want;
      if (predicted_tokens.size() == 0) begin
         mismatch_count++;
         $display("%0t: token mismatch, expected none, actual kind %0d at %0d",
                  $time, rsp_token_kind, rsp_start_pos);
      end else begin
         want = predicted_tokens.pop_front();
         compare_field("token_kind", want.tok.kind, rsp_token_kind);
         compare_field("start_pos", want.tok.start, rsp_start_pos);
         compare_field("token_length", want.tok.length, rsp_token_length);
         compare_field("number_value", want.tok.value, rsp_number_value);
         compare_field("value_overflow", want.tok.ovf, rsp_value_overflow);
         compare_field("token_char", want.tok.chr, rsp_token_char);
         compare_field("last_of_run", want.last, rsp_last_of_run);
      end
   endfunction

   // Prediction comes before comparison so that a token given in the same
   // cycle as its byte would still find its prediction waiting.
   always @(posedge clock) begin
      if (reset) begin
         clear_run_state();
         predicted_tokens.delete();
         mismatch_count = 0;
         tokens_outstanding <= 0;
      end else begin
         if (push && !full) predict_tokens(req_text_byte, req_end_of_text);
         if (pop && !empty) compare_token();
         tokens_outstanding <= predicted_tokens.size();
      end
   end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Arithmetic expression lexer testbench
// Streams short hand-made texts and then random expression texts into the
// lexer, while the token side stalls on a pattern of its own. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import ael_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int RANDOM_BYTES   = 300;

   typedef struct packed {
      logic [7:0] text;
      logic       eot;
   } text_beat_type;

   // How eagerly the token side pops.
   typedef enum int {
      POP_ALWAYS,
      POP_MOSTLY,
      POP_HALF,
      POP_RARELY
   } pop_mode_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        push            = 1'b0;
   logic [7:0]  req_text_byte   = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        pop             = 1'b0;
   logic        full;
   logic        empty;
   logic [3:0]  rsp_token_kind;
   logic [15:0] rsp_start_pos;
   logic [15:0] rsp_token_length;
   logic [30:0] rsp_number_value;
   logic        rsp_value_overflow;
   logic [7:0]  rsp_token_char;
   logic        rsp_last_of_run;

   int            mismatch_count;
   int            tokens_outstanding;
   text_beat_type text_beats[$];
   int            burst_left  = 0;
   int            idle_cycles = 0;
   int            pop_timer   = 0;
   pop_mode_type  pop_mode    = POP_ALWAYS;

   string      big_numbers[4] = '{"2147483647", "2147483648", "99999999999",
                                  "00002147483646"};
   logic [7:0] blanks[6]      = '{CHAR_TAB, 8'h0A, 8'h0B, 8'h0C, CHAR_CR, CHAR_SPACE};
   logic [7:0] operators[6]   = '{CHAR_PLUS, CHAR_MINUS, CHAR_STAR, CHAR_SLASH,
                                  CHAR_LPAREN, CHAR_RPAREN};

   arithmetic_expression_lexer_top uut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .empty              (empty),
      .pop                (pop),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_start_pos      (rsp_start_pos),
      .rsp_token_length   (rsp_token_length),
      .rsp_number_value   (rsp_number_value),
      .rsp_value_overflow (rsp_value_overflow),
      .rsp_token_char     (rsp_token_char),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   lexer_token_checker token_check (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_text_byte      (req_text_byte),
      .req_end_of_text    (req_end_of_text),
      .empty              (empty),
      .pop                (pop),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_start_pos      (rsp_start_pos),
      .rsp_token_length   (rsp_token_length),
      .rsp_number_value   (rsp_number_value),
      .rsp_value_overflow (rsp_value_overflow),
      .rsp_token_char     (rsp_token_char),
      .rsp_last_of_run    (rsp_last_of_run),
      .mismatch_count     (mismatch_count),
      .tokens_outstanding (tokens_outstanding)
   );

   always #10 clock = ~clock;

   // Token side: the pop pattern changes to a random mode whenever its timer runs out.
   always @(posedge clock) begin
      if (pop_timer == 0) begin
         pop_mode  <= pop_mode_type'($urandom_range(0, 3));
         pop_timer <= $urandom_range(20, 120);
      end else begin
         pop_timer <= pop_timer - 1;
      end
      case (pop_mode)
         POP_ALWAYS: pop <= 1'b1;
         POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
         POP_HALF:   pop <= 1'($urandom_range(0, 1));
         default:    pop <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog: ends the run when no beat has moved for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1)) return CHAR_LOW_A + 8'($urandom_range(0, 25));
      return CHAR_UP_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic void add_byte(logic [7:0] c);
      text_beats.push_back(text_beat_type'{c, 1'b0});
   endfunction

   function automatic void add_string(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   // Marks the latest queued byte as the last of its text.
   function automatic void end_text();
      text_beats[text_beats.size() - 1].eot = 1'b1;
   endfunction

   function automatic void add_number();
      if ($urandom_range(0, 9) == 0) begin
         add_string(big_numbers[$urandom_range(0, 3)]);
      end else begin
         repeat ($urandom_range(1, 4)) add_byte(random_digit());
      end
   endfunction

   function automatic void add_word();
      add_byte(random_letter());
      repeat ($urandom_range(0, 5)) add_byte($urandom_range(0, 2) ? random_letter()
                                                                   : random_digit());
   endfunction

   function automatic void add_random_text();
      int pick;
      repeat ($urandom_range(1, 12)) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) add_number();
         else if (pick < 45) add_word();
         else if (pick < 60) repeat ($urandom_range(1, 3)) add_byte(blanks[$urandom_range(0, 5)]);
         else if (pick < 90) add_byte(operators[$urandom_range(0, 5)]);
         else add_byte(8'($urandom_range(0, 255)));
      end
      end_text();
   endfunction

   // Drives every queued byte in bursts with random gaps, one beat per edge
   // when the lexer has room. The burst count carries over into the next call.
   task automatic send_text_beats();
      text_beat_type beat;
      while (text_beats.size() != 0) begin
         beat = text_beats.pop_front();
         if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 40);
         end
         push            <= 1'b1;
         req_text_byte   <= beat.text;
         req_end_of_text <= beat.eot;
         @(posedge clock);
         while (full) @(posedge clock);
         burst_left--;
      end
   endtask

   task automatic wait_for_tokens();
      @(posedge clock);
      while (tokens_outstanding != 0) @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Hand-made texts: every operator, run breaks, digits inside a word,
      // a letter after digits, the byte extremes and the class boundaries.
      add_string("42+ab9 (Z)-*/");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(CHAR_TAB);
      add_byte(CHAR_CR);
      add_string(":@[`{7");
      end_text();
      add_string("9a");
      end_text();
      add_string("x");
      end_text();
      send_text_beats();
      push <= 1'b0;

      // Hold the byte side until every token of the texts so far is out.
      wait_for_tokens();

      // Random expression texts.
      while (text_beats.size() < RANDOM_BYTES) add_random_text();
      send_text_beats();
      push <= 1'b0;

      wait_for_tokens();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && tokens_outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
